// ----- rtl/core/grid_line_of_sight_check_defines.svh -----
// Assertion macros for the grid line-of-sight checker.
// Uses clk and arst_n of the including module; no other dependencies.
`ifndef GRID_LINE_OF_SIGHT_CHECK_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECK_DEFINES_SVH

// same-cycle implication
`define GLOS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/glos_pkg.sv -----
// Package for the grid line-of-sight checker: sequencer states, register
// indexes, register reset values and transaction modes. No dependencies.
package glos_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL_MUL,
		ST_CELL_CLIP,
		ST_SCAN,
		ST_DRAIN,
		ST_STEP,
		ST_DONE
	} glos_state_t;

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ALLOW_UNKNOWN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CELL_RATIO = 3'd4;

	localparam logic signed [7:0] THRESHOLD_RST = 8'sd50;
	localparam logic ALLOW_UNKNOWN_RST = 1'b1;
	localparam logic [8:0] MAP_WIDTH_RST = 9'd256;
	localparam logic [8:0] MAP_HEIGHT_RST = 9'd256;
	localparam logic [4:0] CELL_RATIO_RST = 5'd1;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

endpackage

// ----- rtl/core/grid_line_of_sight_check.sv -----
// Grid line-of-sight checker: occupancy map store plus a Bresenham walk sequencer.
// Depends on glos_pkg, glos_ram and grid_line_of_sight_check_defines.svh.
//
// Input transactions with tuser = 0 write one signed occupancy value into the map
// and give no result. Transactions with tuser = 1 query the Bresenham line between
// two planner cells and return one transaction whose tdata bit 0 is 1 when every
// planner cell on the line is free. The input is not ready while a query runs. For
// each planner cell the sequencer passes CELL_MUL and CELL_CLIP, scans the in-map
// cells one cell per cycle, since the map has one read port, then passes DRAIN and
// STEP; DONE hands off the result. The walk stops at the first blocked cell. A new
// transaction is taken while the previous result still waits on the output. The
// map has no reset; queries must only cover written cells.
`include "grid_line_of_sight_check_defines.svh"

module grid_line_of_sight_check #(
	parameter int MAP_SIDE = 256,
	parameter int MAX_CELL_RATIO = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// map_x[7:0], map_y[15:8], occupancy[23:16], from_x[31:24], from_y[39:32],
	// to_x[47:40], to_y[55:48]
	input  logic [55:0] s_axis_tdata,
	// mode[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// line_clear[0], zero fill above
	output logic [7:0]  m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic [glos_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [glos_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
	localparam int DEPTH = MAP_SIDE * MAP_SIDE;
	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(MAX_CELL_RATIO + 1);
	localparam int XW = 8 + RW + 1;
	localparam int SW = $clog2(MAP_SIDE + 1);
	localparam int CW0 = (XW > SW) ? XW : SW;
	localparam int CW = (CW0 > 10) ? CW0 : 10;

	glos_pkg::glos_state_t state_q, state_d;

	// configuration
	logic signed [7:0] thr_q;
	logic              allow_q;
	logic [8:0]        map_w_q, map_h_q;
	logic [4:0]        ratio_q;

	logic [CW-1:0] ratio_ext, w_ext, h_ext, w_eff, h_eff;
	logic [RW-1:0] r_eff;

	// walk state
	logic [7:0]         x_q, y_q, x1_q, y1_q, dx_q, ady_q;
	logic               sx_q, sy_q;
	logic signed [10:0] err_q;
	logic [CW-1:0]      xlo_q, ylo_q, xhi_q, yhi_q, cx_q, cy_q;
	logic               rd_vld_s1;
	logic               clear_q;

	logic               m_valid_q;
	logic               m_clear_q;

	// input fields
	logic [7:0] in_map_x, in_map_y, in_occ, in_from_x, in_from_y, in_to_x, in_to_y;
	logic       in_acc;
	logic [7:0] in_dx, in_ady;

	// datapath helpers
	logic [CW-1:0]      wx, wy, xhi_raw, yhi_raw;
	logic               wr_in_map;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [7:0]         rd_data;
	logic               rd_bad, outside, scan_last_x, scan_last, at_end;
	logic signed [11:0] e2, ady_s, dx_s;
	logic               step_x, step_y;
	logic signed [10:0] err_nxt;

	// controls from the sequencer
	logic s_ready, ram_wr_en, ram_rd_en, out_free, out_load;

	assign in_map_x  = s_axis_tdata[7:0];
	assign in_map_y  = s_axis_tdata[15:8];
	assign in_occ    = s_axis_tdata[23:16];
	assign in_from_x = s_axis_tdata[31:24];
	assign in_from_y = s_axis_tdata[39:32];
	assign in_to_x   = s_axis_tdata[47:40];
	assign in_to_y   = s_axis_tdata[55:48];
	assign in_acc    = s_axis_tvalid && s_ready;
	assign in_dx  = (in_to_x > in_from_x) ? (in_to_x - in_from_x) : (in_from_x - in_to_x);
	assign in_ady = (in_to_y > in_from_y) ? (in_to_y - in_from_y) : (in_from_y - in_to_y);

	// effective ratio and clamped map size
	assign ratio_ext = CW'(ratio_q);
	always_comb begin
		if (ratio_ext == '0) begin
			r_eff = RW'(1);
		end else if (ratio_ext > CW'(MAX_CELL_RATIO)) begin
			r_eff = RW'(MAX_CELL_RATIO);
		end else begin
			r_eff = RW'(ratio_ext);
		end
	end
	assign w_ext = CW'(map_w_q);
	assign h_ext = CW'(map_h_q);
	assign w_eff = (w_ext > CW'(MAP_SIDE)) ? CW'(MAP_SIDE) : w_ext;
	assign h_eff = (h_ext > CW'(MAP_SIDE)) ? CW'(MAP_SIDE) : h_ext;

	// map write address
	assign wx = CW'(in_map_x);
	assign wy = CW'(in_map_y);
	assign wr_in_map = (wx < CW'(MAP_SIDE)) && (wy < CW'(MAP_SIDE));
	assign wr_addr = AW'(wy[IW-1:0]) * AW'(MAP_SIDE) + AW'(wx[IW-1:0]);
	assign rd_addr = AW'(cy_q[IW-1:0]) * AW'(MAP_SIDE) + AW'(cx_q[IW-1:0]);

	glos_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_map (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(wr_addr),
		.wr_data(in_occ),
		.rd_en  (ram_rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_bad = ($signed(rd_data) > thr_q) || (rd_data[7] && !allow_q);

	// cell clipping
	assign xhi_raw = xlo_q + CW'(r_eff);
	assign yhi_raw = ylo_q + CW'(r_eff);
	assign outside = (xlo_q >= w_eff) || (ylo_q >= h_eff);

	assign scan_last_x = (cx_q + CW'(1)) == xhi_q;
	assign scan_last   = scan_last_x && ((cy_q + CW'(1)) == yhi_q);

	// Bresenham step
	assign at_end  = (x_q == x1_q) && (y_q == y1_q);
	assign e2      = {err_q[10], err_q} <<< 1;
	assign ady_s   = $signed({4'b0, ady_q});
	assign dx_s    = $signed({4'b0, dx_q});
	assign step_x  = e2 >= -ady_s;
	assign step_y  = e2 <= dx_s;
	assign err_nxt = err_q - (step_x ? $signed({3'b0, ady_q}) : 11'sd0)
		+ (step_y ? $signed({3'b0, dx_q}) : 11'sd0);

	assign out_free = !m_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			glos_pkg::ST_IDLE: begin
				if (in_acc && (s_axis_tuser == glos_pkg::MODE_QUERY)) begin
					state_d = glos_pkg::ST_CELL_MUL;
				end
			end
			glos_pkg::ST_CELL_MUL: begin
				state_d = glos_pkg::ST_CELL_CLIP;
			end
			glos_pkg::ST_CELL_CLIP: begin
				state_d = outside ? glos_pkg::ST_DONE : glos_pkg::ST_SCAN;
			end
			glos_pkg::ST_SCAN: begin
				if (rd_vld_s1 && rd_bad) begin
					state_d = glos_pkg::ST_DONE;
				end else if (scan_last) begin
					state_d = glos_pkg::ST_DRAIN;
				end
			end
			glos_pkg::ST_DRAIN: begin
				state_d = rd_bad ? glos_pkg::ST_DONE : glos_pkg::ST_STEP;
			end
			glos_pkg::ST_STEP: begin
				state_d = at_end ? glos_pkg::ST_DONE : glos_pkg::ST_CELL_MUL;
			end
			glos_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = glos_pkg::ST_IDLE;
				end
			end
			default: state_d = glos_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_ready   = 1'b0;
		ram_wr_en = 1'b0;
		ram_rd_en = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			glos_pkg::ST_IDLE: begin
				s_ready   = 1'b1;
				ram_wr_en = s_axis_tvalid && (s_axis_tuser == glos_pkg::MODE_WRITE)
					&& wr_in_map;
			end
			glos_pkg::ST_SCAN: ram_rd_en = 1'b1;
			glos_pkg::ST_DONE: out_load = out_free;
			glos_pkg::ST_CELL_MUL, glos_pkg::ST_CELL_CLIP, glos_pkg::ST_DRAIN,
			glos_pkg::ST_STEP: begin
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= glos_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_rd_en;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= glos_pkg::THRESHOLD_RST;
			allow_q <= glos_pkg::ALLOW_UNKNOWN_RST;
			map_w_q <= glos_pkg::MAP_WIDTH_RST;
			map_h_q <= glos_pkg::MAP_HEIGHT_RST;
			ratio_q <= glos_pkg::CELL_RATIO_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				glos_pkg::REG_THRESHOLD:     thr_q   <= $signed(cfg_data[7:0]);
				glos_pkg::REG_ALLOW_UNKNOWN: allow_q <= cfg_data[0];
				glos_pkg::REG_MAP_WIDTH:     map_w_q <= cfg_data[8:0];
				glos_pkg::REG_MAP_HEIGHT:    map_h_q <= cfg_data[8:0];
				glos_pkg::REG_CELL_RATIO:    ratio_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			glos_pkg::ST_IDLE: begin
				x_q   <= in_from_x;
				y_q   <= in_from_y;
				x1_q  <= in_to_x;
				y1_q  <= in_to_y;
				dx_q  <= in_dx;
				ady_q <= in_ady;
				sx_q  <= in_from_x < in_to_x;
				sy_q  <= in_from_y < in_to_y;
				err_q <= $signed({3'b0, in_dx}) - $signed({3'b0, in_ady});
			end
			glos_pkg::ST_CELL_MUL: begin
				xlo_q <= CW'(x_q) * CW'(r_eff);
				ylo_q <= CW'(y_q) * CW'(r_eff);
			end
			glos_pkg::ST_CELL_CLIP: begin
				xhi_q <= (xhi_raw > w_eff) ? w_eff : xhi_raw;
				yhi_q <= (yhi_raw > h_eff) ? h_eff : yhi_raw;
				cx_q  <= xlo_q;
				cy_q  <= ylo_q;
				if (outside) begin
					clear_q <= 1'b0;
				end
			end
			glos_pkg::ST_SCAN: begin
				if (scan_last_x) begin
					cx_q <= xlo_q;
					cy_q <= cy_q + CW'(1);
				end else begin
					cx_q <= cx_q + CW'(1);
				end
				if (rd_vld_s1 && rd_bad) begin
					clear_q <= 1'b0;
				end
			end
			glos_pkg::ST_DRAIN: begin
				if (rd_bad) begin
					clear_q <= 1'b0;
				end
			end
			glos_pkg::ST_STEP: begin
				if (at_end) begin
					clear_q <= 1'b1;
				end else begin
					err_q <= err_nxt;
					if (step_x) begin
						x_q <= sx_q ? (x_q + 8'd1) : (x_q - 8'd1);
					end
					if (step_y) begin
						y_q <= sy_q ? (y_q + 8'd1) : (y_q - 8'd1);
					end
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_clear_q <= clear_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_clear_q};

	`GLOS_ASSERT_IMPL(a_map_port_exclusive, ram_wr_en, !ram_rd_en, "map read and write in one cycle")
	`GLOS_ASSERT_IMPL(a_scan_in_map, state_q == glos_pkg::ST_SCAN, (cx_q < w_eff) && (cy_q < h_eff), "scan left the map")
	`GLOS_ASSERT_NEXT(a_query_starts, in_acc && s_axis_tuser, state_q == glos_pkg::ST_CELL_MUL, "query did not start the walk")
	`GLOS_ASSERT_NEXT(a_result_loaded, out_load, m_axis_tvalid && (m_axis_tdata[0] == $past(clear_q)), "result not presented")

endmodule

// ----- rtl/core/glos_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module glos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- tb/tb_grid_line_of_sight_check.sv -----
// Self-checking testbench for grid_line_of_sight_check: preloads the whole map,
// runs a directed table, then random writes and line queries over several register
// settings, checking results against typed values or a Bresenham line predictor. Needs glos_pkg.
`timescale 1ns / 1ps

module tb_grid_line_of_sight_check;
	import glos_pkg::*;

	localparam int MAP_SIDE = 256;
	localparam int MAX_RATIO = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 8;
	localparam int NO_PREDICT = -1;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_FIXED_PHASES = 6;
	localparam int NUM_PHASES = 8;
	localparam int NUM_ROWS = 34;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_QUERY,
		ROW_CFG
	} row_kind_e;

	// write: a=x b=y c=occupancy; query: a,b -> c,d; cfg: a=index b=value
	typedef struct packed {
		row_kind_e kind;
		int a;
		int b;
		int c;
		int d;
		int clear;
	} stim_row_t;

	typedef struct packed {
		int thr;
		int allow;
		int w;
		int h;
		int ratio;
		int idle;
	} phase_cfg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic s_axis_tuser = MODE_WRITE;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_wr_en = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic signed [7:0] occ_model [0:MAP_SIDE*MAP_SIDE-1];
	logic signed [7:0] thr_q = THRESHOLD_RST;
	logic allow_q = ALLOW_UNKNOWN_RST;
	logic [8:0] width_q = MAP_WIDTH_RST;
	logic [8:0] height_q = MAP_HEIGHT_RST;
	logic [4:0] ratio_q = CELL_RATIO_RST;

	bit clear_expected_q [$];
	int mismatch_count = 0;
	int idle_pct = 31;
	int quiet_cycles = 0;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ROW_WRITE, 0, 0, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 1},
		'{ROW_WRITE, 0, 0, 127, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 0},
		'{ROW_WRITE, 0, 0, -128, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 1},
		'{ROW_CFG, REG_ALLOW_UNKNOWN, 0, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_THRESHOLD, 127, 0, 0, NO_PREDICT},
		'{ROW_WRITE, 0, 0, 127, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 1},
		'{ROW_WRITE, 255, 255, -1, 0, NO_PREDICT},
		'{ROW_QUERY, 255, 255, 255, 255, 0},
		'{ROW_QUERY, 0, 0, 255, 255, NO_PREDICT},
		'{ROW_QUERY, 255, 0, 0, 255, NO_PREDICT},
		'{ROW_CFG, REG_THRESHOLD, -128, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 1, 1, 1, 1, 0},
		'{ROW_CFG, REG_MAP_WIDTH, 0, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_MAP_WIDTH, 511, 0, 0, NO_PREDICT},
		'{ROW_CFG, REG_THRESHOLD, 127, 0, 0, NO_PREDICT},
		'{ROW_CFG, REG_ALLOW_UNKNOWN, 1, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 255, 255, 1},
		'{ROW_CFG, REG_CELL_RATIO, 0, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 3, 200, 250, 7, 1},
		'{ROW_CFG, REG_CELL_RATIO, 31, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 15, 15, 1},
		'{ROW_QUERY, 16, 0, 16, 0, 0},
		'{ROW_CFG, REG_MAP_HEIGHT, 1, 0, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 0, 0, 1},
		'{ROW_QUERY, 0, 1, 0, 1, 0},
		'{ROW_QUERY, 15, 0, 0, 0, NO_PREDICT},
		'{ROW_WRITE, 20, 0, 100, 0, NO_PREDICT},
		'{ROW_QUERY, 0, 0, 15, 0, NO_PREDICT}
	};

	phase_cfg_t fixed_phases [NUM_FIXED_PHASES] = '{
		'{50, 1, 256, 256, 1, 31},
		'{127, 0, 256, 256, 16, 31},
		'{-128, 1, 1, 1, 1, 31},
		'{30, 0, 200, 100, 3, 31},
		'{100, 1, 256, 256, 15, 0},
		'{127, 1, 511, 300, 31, 31}
	};

	grid_line_of_sight_check #(
		.MAP_SIDE(MAP_SIDE),
		.MAX_CELL_RATIO(MAX_RATIO)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int cell_ratio();
		if (ratio_q == 0)
			return 1;
		if (ratio_q > MAX_RATIO)
			return MAX_RATIO;
		return int'(ratio_q);
	endfunction

	function automatic int clip_side(logic [8:0] v);
		return (v > MAP_SIDE) ? MAP_SIDE : int'(v);
	endfunction

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : ((v > 255) ? 255 : v);
	endfunction

	function automatic bit planner_cell_blocked(int gx, int gy);
		int r, w, h, xlo, ylo, xhi, yhi, x, y;
		logic signed [7:0] v;
		r = cell_ratio();
		w = clip_side(width_q);
		h = clip_side(height_q);
		if (gx < 0 || gy < 0)
			return 1'b1;
		xlo = gx * r;
		ylo = gy * r;
		if (xlo >= w || ylo >= h)
			return 1'b1;
		xhi = (xlo + r > w) ? w : xlo + r;
		yhi = (ylo + r > h) ? h : ylo + r;
		for (y = ylo; y < yhi; y++) begin
			for (x = xlo; x < xhi; x++) begin
				v = occ_model[y * MAP_SIDE + x];
				if (v > thr_q)
					return 1'b1;
				if (v < 0 && !allow_q)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit predict_line_clear(int x0, int y0, int x1, int y1);
		int dx, dy, sx, sy, err, e2;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
		sx = (x0 < x1) ? 1 : -1;
		sy = (y0 < y1) ? 1 : -1;
		err = dx + dy;
		while (1) begin
			if (planner_cell_blocked(x0, y0))
				return 1'b0;
			if (x0 == x1 && y0 == y1)
				return 1'b1;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x0 += sx;
			end
			if (e2 <= dx) begin
				err += dx;
				y0 += sy;
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50)
			$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// present one transaction, with random idle cycles ahead of it
	task automatic send_item(input logic mode, input logic [55:0] data, input int typed_clear);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= mode;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (mode == MODE_WRITE)
			occ_model[{data[15:8], data[7:0]}] = data[23:16];
		else if (typed_clear == NO_PREDICT)
			clear_expected_q.push_back(predict_line_clear(data[31:24], data[39:32],
				data[47:40], data[55:48]));
		else
			clear_expected_q.push_back(typed_clear[0]);
	endtask

	task automatic write_item(input int x, input int y, input int occ);
		send_item(MODE_WRITE, {32'($urandom), 8'(occ), 8'(y), 8'(x)}, NO_PREDICT);
	endtask

	task automatic query_item(input int fx, input int fy, input int tx, input int ty,
			input int typed_clear);
		send_item(MODE_QUERY, {8'(ty), 8'(tx), 8'(fy), 8'(fx), 8'($urandom), 8'($urandom),
			8'($urandom)}, typed_clear);
	endtask

	// drop valid, wait for all results, then let a write finish
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (clear_expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] word;
		case (idx)
			REG_THRESHOLD: mask = 9'h0FF;
			REG_ALLOW_UNKNOWN: mask = 9'h001;
			REG_CELL_RATIO: mask = 9'h01F;
			default: mask = 9'h1FF;
		endcase
		word = (value[8:0] & mask) | (9'($urandom) & ~mask);
		case (idx)
			REG_THRESHOLD: thr_q = word[7:0];
			REG_ALLOW_UNKNOWN: allow_q = word[0];
			REG_MAP_WIDTH: width_q = word;
			REG_MAP_HEIGHT: height_q = word;
			REG_CELL_RATIO: ratio_q = word[4:0];
			default: ;
		endcase
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input phase_cfg_t pc);
		settle();
		write_reg(REG_THRESHOLD, pc.thr);
		write_reg(REG_ALLOW_UNKNOWN, pc.allow);
		write_reg(REG_MAP_WIDTH, pc.w);
		write_reg(REG_MAP_HEIGHT, pc.h);
		write_reg(REG_CELL_RATIO, pc.ratio);
		idle_pct = pc.idle;
	endtask

	task automatic random_item();
		int r, w, h, sel, x, y, occ, gxn, gyn, span, fx, fy, tx, ty;
		r = cell_ratio();
		w = clip_side(width_q);
		h = clip_side(height_q);
		if ($urandom_range(99) < 50) begin
			x = (w > 0 && $urandom_range(99) < 70) ? $urandom_range(0, w - 1) : $urandom_range(0, 255);
			y = (h > 0 && $urandom_range(99) < 70) ? $urandom_range(0, h - 1) : $urandom_range(0, 255);
			sel = $urandom_range(99);
			if (sel < 70)
				occ = $urandom_range(0, 40);
			else if (sel < 85) begin
				case ($urandom_range(5))
					0: occ = -128;
					1: occ = -1;
					2: occ = 0;
					3: occ = 127;
					4: occ = thr_q;
					default: occ = (thr_q == 127) ? 127 : thr_q + 1;
				endcase
			end else
				occ = int'($urandom_range(0, 255)) - 128;
			write_item(x, y, occ);
		end else begin
			if ($urandom_range(99) < 15) begin
				fx = $urandom_range(0, 255);
				fy = $urandom_range(0, 255);
				tx = $urandom_range(0, 255);
				ty = $urandom_range(0, 255);
			end else begin
				gxn = clamp_coord((w + r - 1) / r);
				gyn = clamp_coord((h + r - 1) / r);
				span = (24 / r < 2) ? 2 : 24 / r;
				fx = $urandom_range(0, gxn);
				fy = $urandom_range(0, gyn);
				tx = clamp_coord(fx + int'($urandom_range(0, 2 * span)) - span);
				ty = clamp_coord(fy + int'($urandom_range(0, 2 * span)) - span);
			end
			query_item(fx, fy, tx, ty, NO_PREDICT);
		end
	endtask

	always @(posedge clk) begin : result_check
		bit expected_clear;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (clear_expected_q.size() == 0)
					report_mismatch("result transaction with no query pending");
				else begin
					expected_clear = clear_expected_q.pop_front();
					if (m_axis_tdata !== {7'b0, expected_clear})
						report_mismatch($sformatf("line_clear tdata %h, expected %0d",
							m_axis_tdata, expected_clear));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		int sel;
		phase_cfg_t pc;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every map cell: mostly free, a few obstacles and unknowns
		for (int y = 0; y < MAP_SIDE; y++) begin
			for (int x = 0; x < MAP_SIDE; x++) begin
				sel = $urandom_range(999);
				if (sel < 15)
					write_item(x, y, $urandom_range(51, 127));
				else if (sel < 30)
					write_item(x, y, int'($urandom_range(0, 127)) - 128);
				else
					write_item(x, y, $urandom_range(0, 40));
			end
		end

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_WRITE: write_item(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c);
				ROW_QUERY: query_item(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
					directed_rows[i].d, directed_rows[i].clear);
				default: begin
					settle();
					write_reg(directed_rows[i].a[REG_IDX_W-1:0], directed_rows[i].b);
				end
			endcase
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < NUM_FIXED_PHASES)
				pc = fixed_phases[p];
			else begin
				pc.thr = ($urandom_range(99) < 50) ? $urandom_range(40, 127)
					: int'($urandom_range(0, 255)) - 128;
				pc.allow = $urandom_range(0, 1);
				pc.w = $urandom_range(1, 511);
				pc.h = $urandom_range(1, 511);
				pc.ratio = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(0, 31);
				pc.idle = 31;
			end
			set_config(pc);
			repeat (ITEMS_PER_PHASE) random_item();
		end

		settle();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
